FILE: hw/rtl/pctesc_pkg.sv
// Package for the percent / escape dequoter: types, character constants,
// mode codes and small character classification functions.
// No dependencies; used by every module of the block.
`default_nettype none

package pctesc_pkg;

    // Most result transactions that one input byte can cause.
    localparam int MAX_RESULTS = 3;
    // Default depth of the result queue (power of two, at least 4).
    localparam int QUEUE_DEPTH_DEF = 8;
    // Configuration port address width and register data width.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register indexes.
    localparam logic REG_QUOTE_MODE = 1'b0;

    // Quote modes. Codes five to seven behave as pass-through.
    localparam logic [2:0] MODE_NONE       = 3'd0;
    localparam logic [2:0] MODE_URI        = 3'd1;
    localparam logic [2:0] MODE_ESC        = 3'd2;
    localparam logic [2:0] MODE_STRICT_URI = 3'd3;
    localparam logic [2:0] MODE_STRICT_ESC = 3'd4;

    // Characters that steer the parser.
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PCT1,
        PH_PCT2,
        PH_BSL,
        PH_OCT1,
        PH_OCT2,
        PH_DROP
    } t_phase;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        t_phase     phase;
        logic [7:0] held;
        logic [7:0] octv;
    } t_pstate;

    // One result transaction.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_result;

    function automatic logic is_hex(input logic [7:0] b);
        return b inside {[CH_ZERO:CH_NINE], [CH_LO_A:CH_LO_F], [CH_UP_A:CH_UP_F]};
    endfunction

    function automatic logic is_oct(input logic [7:0] b);
        return b inside {[CH_ZERO:CH_SEVEN]};
    endfunction

    // Value of a hex digit; letters of either case fold onto lower case.
    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] t;
        t = (b | CASE_BIT) - CH_LO_A + HEX_TEN;
        if (b inside {[CH_ZERO:CH_NINE]}) begin
            t = b - CH_ZERO;
        end
        return t[3:0];
    endfunction

    // Control code named by the letter after a backslash.
    function automatic logic [7:0] esc_map(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            CH_N: r = 8'd10;
            CH_T: r = 8'd9;
            CH_R: r = 8'd13;
            CH_B: r = 8'd8;
            CH_F: r = 8'd12;
            CH_V: r = 8'd11;
            default: r = b;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pctesc_parse.sv
// Combinational parser step: one input byte plus the carried parser state
// gives the next state and up to three result transactions.
// Depends on pctesc_pkg.
`default_nettype none

module pctesc_parse
    import pctesc_pkg::*;
(
    input  logic [2:0]                    i_mode,
    input  t_pstate                       i_state,
    input  logic [7:0]                    i_byte,
    input  logic                          i_last,
    output t_pstate                       o_state,
    output t_result [MAX_RESULTS-1:0]     o_items,
    output logic [1:0]                    o_count
);

    logic                      uri;
    logic                      strict;
    logic                      esc;
    t_pstate                   st;
    t_result [MAX_RESULTS-1:0] res;
    logic [1:0]                cnt;
    logic [7:0]                digit;

    assign uri    = (i_mode == MODE_URI) || (i_mode == MODE_STRICT_URI);
    assign strict = (i_mode == MODE_STRICT_URI);
    assign esc    = (i_mode == MODE_ESC) || (i_mode == MODE_STRICT_ESC);
    assign digit  = i_byte - CH_ZERO;

    // Walk the byte through the current phase, appending results in order.
    always_comb begin
        st  = i_state;
        res = '0;
        cnt = 2'd0;
        if (uri) begin
            case (st.phase)
                PH_PCT1: begin
                    if (is_hex(i_byte)) begin
                        st.held  = i_byte;
                        st.phase = PH_PCT2;
                    end else if (strict) begin
                        st.phase = PH_DROP;
                    end else begin
                        res[cnt] = '{data: CH_PCT, last: 1'b0, err: 1'b0};
                        cnt = cnt + 2'd1;
                        if (i_byte == CH_PCT) begin
                            st.phase = PH_PCT1;
                        end else begin
                            st.phase = PH_IDLE;
                            res[cnt] = '{data: i_byte, last: 1'b0, err: 1'b0};
                            cnt = cnt + 2'd1;
                        end
                    end
                end
                PH_PCT2: begin
                    if (is_hex(i_byte)) begin
                        res[cnt] = '{data: {hex_val(st.held), hex_val(i_byte)},
                                     last: 1'b0, err: 1'b0};
                        cnt = cnt + 2'd1;
                        st.held  = 8'd0;
                        st.phase = PH_IDLE;
                    end else if (strict) begin
                        st.phase = PH_DROP;
                    end else begin
                        res[cnt] = '{data: CH_PCT, last: 1'b0, err: 1'b0};
                        cnt = cnt + 2'd1;
                        res[cnt] = '{data: st.held, last: 1'b0, err: 1'b0};
                        cnt = cnt + 2'd1;
                        st.held = 8'd0;
                        if (i_byte == CH_PCT) begin
                            st.phase = PH_PCT1;
                        end else begin
                            st.phase = PH_IDLE;
                            res[cnt] = '{data: i_byte, last: 1'b0, err: 1'b0};
                            cnt = cnt + 2'd1;
                        end
                    end
                end
                PH_DROP: begin
                end
                default: begin
                    if (i_byte == CH_PCT) begin
                        st.phase = PH_PCT1;
                    end else begin
                        st.phase = PH_IDLE;
                        res[cnt] = '{data: i_byte, last: 1'b0, err: 1'b0};
                        cnt = cnt + 2'd1;
                    end
                end
            endcase
            // A sequence cut off by the end of the string.
            if (i_last) begin
                if (st.phase == PH_PCT1 || st.phase == PH_PCT2) begin
                    if (strict) begin
                        st.phase = PH_DROP;
                    end else begin
                        res[cnt] = '{data: CH_PCT, last: 1'b0, err: 1'b0};
                        cnt = cnt + 2'd1;
                        if (st.phase == PH_PCT2) begin
                            res[cnt] = '{data: st.held, last: 1'b0, err: 1'b0};
                            cnt = cnt + 2'd1;
                        end
                    end
                end
                if (st.phase == PH_DROP) begin
                    res[cnt] = '{data: 8'd0, last: 1'b0, err: 1'b1};
                    cnt = cnt + 2'd1;
                end
            end
        end else if (esc) begin
            case (st.phase)
                PH_BSL: begin
                    if (is_oct(i_byte)) begin
                        st.octv  = digit;
                        st.phase = PH_OCT1;
                    end else begin
                        res[cnt] = '{data: esc_map(i_byte), last: 1'b0, err: 1'b0};
                        cnt = cnt + 2'd1;
                        st.phase = PH_IDLE;
                    end
                end
                PH_OCT1: begin
                    if (is_oct(i_byte)) begin
                        st.octv  = {st.octv[4:0], 3'b000} + digit;
                        st.phase = PH_OCT2;
                    end else begin
                        res[cnt] = '{data: st.octv, last: 1'b0, err: 1'b0};
                        cnt = cnt + 2'd1;
                        st.octv = 8'd0;
                        if (i_byte == CH_BSL) begin
                            st.phase = PH_BSL;
                        end else begin
                            st.phase = PH_IDLE;
                            res[cnt] = '{data: i_byte, last: 1'b0, err: 1'b0};
                            cnt = cnt + 2'd1;
                        end
                    end
                end
                PH_OCT2: begin
                    if (is_oct(i_byte)) begin
                        res[cnt] = '{data: {st.octv[4:0], 3'b000} + digit,
                                     last: 1'b0, err: 1'b0};
                        cnt = cnt + 2'd1;
                        st.phase = PH_IDLE;
                    end else begin
                        res[cnt] = '{data: st.octv, last: 1'b0, err: 1'b0};
                        cnt = cnt + 2'd1;
                        if (i_byte == CH_BSL) begin
                            st.phase = PH_BSL;
                        end else begin
                            st.phase = PH_IDLE;
                            res[cnt] = '{data: i_byte, last: 1'b0, err: 1'b0};
                            cnt = cnt + 2'd1;
                        end
                    end
                    st.octv = 8'd0;
                end
                default: begin
                    if (i_byte == CH_BSL) begin
                        st.phase = PH_BSL;
                    end else begin
                        st.phase = PH_IDLE;
                        res[cnt] = '{data: i_byte, last: 1'b0, err: 1'b0};
                        cnt = cnt + 2'd1;
                    end
                end
            endcase
            // A trailing backslash gives zero; trailing digits give their value.
            if (i_last) begin
                if (st.phase == PH_BSL) begin
                    res[cnt] = '{data: 8'd0, last: 1'b0, err: 1'b0};
                    cnt = cnt + 2'd1;
                end else if (st.phase == PH_OCT1 || st.phase == PH_OCT2) begin
                    res[cnt] = '{data: st.octv, last: 1'b0, err: 1'b0};
                    cnt = cnt + 2'd1;
                end
            end
        end else begin
            res[cnt] = '{data: i_byte, last: 1'b0, err: 1'b0};
            cnt = cnt + 2'd1;
        end

        // Mark the final result of the string and return to the idle state.
        if (i_last) begin
            if (cnt != 2'd0) begin
                res[cnt - 2'd1].last = 1'b1;
            end
            st = '{phase: PH_IDLE, held: 8'd0, octv: 8'd0};
        end
    end

    assign o_state = st;
    assign o_items = res;
    assign o_count = cnt;

endmodule

`default_nettype wire

FILE: hw/rtl/pctesc_queue.sv
// Result queue: takes up to three results in one cycle and hands them out
// one per transaction from its head.
// Depends on pctesc_pkg.
`default_nettype none

module pctesc_queue
    import pctesc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_push_cnt,
    input  t_result [MAX_RESULTS-1:0]     i_items,
    input  logic                          i_pop,
    output t_result                       o_head,
    output logic [$clog2(DEPTH+1)-1:0]    o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result          r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_wr;
    logic [AW-1:0]    n_rd;
    logic [CW-1:0]    n_count;

    // Pointer and fill bookkeeping.
    always_comb begin
        n_wr    = r_wr + AW'(i_push_cnt);
        n_rd    = r_rd + AW'(i_pop);
        n_count = r_count + CW'(i_push_cnt) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store the new results at consecutive slots.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (2'(k) < i_push_cnt) begin
                r_mem[r_wr + AW'(k)] <= i_items[k];
            end
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

`default_nettype wire

FILE: hw/rtl/percent_or_escape_dequoter_core.sv
// Top level of the percent / escape dequoter: stream ports, the quote mode
// register on the configuration port, the parser state and the result queue.
// Depends on pctesc_pkg, pctesc_parse and pctesc_queue.
`default_nettype none

// The block takes one byte of a quoted string per cycle and dequotes it on
// the fly: URI modes decode %hh, escape modes decode backslash sequences with
// up to three octal digits, and mode none passes bytes through. Each input
// byte is parsed in the cycle it is accepted and its zero to three results
// are written into a result queue, which delivers one result per cycle while
// m_tready is high; the results are registered in the queue before they
// reach the output. The input accepts a byte every cycle as long as the queue
// has at least three free slots, that is while at most QUEUE_DEPTH minus
// three results are waiting, so a stalled output lets QUEUE_DEPTH minus two
// up to QUEUE_DEPTH results pile up before the input stalls. Only the rare
// sequences that give two or three results (a bad or cut-off percent
// sequence, an octal run ended by another byte) produce more results than
// bytes, and the queue absorbs those bursts. Writing quote_mode returns the
// parser to idle; do so only while the block is idle.

module percent_or_escape_dequoter_core
    import pctesc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input stream.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] in_byte
    input  logic              s_tlast,   // in_last
    // Output stream.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] out_byte
    output logic              m_tlast,   // out_last
    output logic [0:0]        m_tuser,   // [0] format_error
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [2:0]                r_mode;
    t_pstate                   r_state;
    t_pstate                   n_state;
    t_pstate                   parse_state;
    t_result [MAX_RESULTS-1:0] parse_items;
    logic [1:0]                parse_cnt;
    logic [1:0]                push_cnt;
    logic                      in_acc;
    logic                      out_acc;
    logic                      cfg_wr;
    t_result                   head;
    logic [CW-1:0]             q_count;

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_QUOTE_MODE);
    assign prdata = (paddr[2] == REG_QUOTE_MODE) ? {{(APB_DW-3){1'b0}}, r_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
        end else if (cfg_wr) begin
            r_mode <= pwdata[2:0];
        end
    end

    // Parser for the byte being accepted.
    pctesc_parse u_parse (
        .i_mode  (r_mode),
        .i_state (r_state),
        .i_byte  (s_tdata),
        .i_last  (s_tlast),
        .o_state (parse_state),
        .o_items (parse_items),
        .o_count (parse_cnt)
    );

    // Input side handshake: room for the largest burst of one byte.
    assign s_tready = (q_count <= CW'(QUEUE_DEPTH - MAX_RESULTS));
    assign in_acc   = s_tvalid & s_tready;
    assign push_cnt = in_acc ? parse_cnt : 2'd0;

    // Parser state register; a mode write restarts the parser.
    always_comb begin
        n_state = r_state;
        if (cfg_wr) begin
            n_state = '{phase: PH_IDLE, held: 8'd0, octv: 8'd0};
        end else if (in_acc) begin
            n_state = parse_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, held: 8'd0, octv: 8'd0};
        end else begin
            r_state <= n_state;
        end
    end

    // Result queue and output side.
    assign out_acc = m_tvalid & m_tready;

    pctesc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_items    (parse_items),
        .i_pop      (out_acc),
        .o_head     (head),
        .o_count    (q_count)
    );

    assign m_tvalid   = (q_count != '0);
    assign m_tdata    = head.data;
    assign m_tlast    = head.last;
    assign m_tuser[0] = head.err;

`ifndef NO_ASSERTIONS
    // The queue never holds more than its depth.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    // A mode write leaves the parser idle with nothing held.
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_state.phase == PH_IDLE && r_state.held == 8'd0 &&
                    r_state.octv == 8'd0))
        else $error("parser not cleared by mode write");

    // The end of a string returns the parser to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_tlast && !cfg_wr) |=> (r_state.phase == PH_IDLE))
        else $error("parser not idle after end of string");

    // An error result carries a zero byte and closes its string.
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'd0 && m_tlast))
        else $error("malformed error result");

    // Pass-through mode gives exactly one result per byte.
    a_none_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_mode == MODE_NONE) |-> (push_cnt == 2'd1))
        else $error("pass-through result count wrong");
`endif

endmodule

`default_nettype wire
